FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the agent time table checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert a property on a given clock, disabled while the given reset is high
`define ALVT_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("agent time table assertion failed");

// Assert a property on the block clock and reset
`define ALVT_ASSERT_CLK(name, prop) \
   `ALVT_ASSERT(name, clock, reset, prop)

`endif

FILE: hdl/alvt_pkg.sv
// ----------------------------------------------------------------------------
// alvt_pkg
// Widths, command and status codes, stream packing and entry type of the
// agent local virtual time table.
// ----------------------------------------------------------------------------
package alvt_pkg;

   localparam int ENTRIES_DEF = 32;
   localparam int ID_BITS     = 16;
   localparam int TIME_BITS   = 32;
   localparam int CMD_BITS    = 2;
   localparam int STATUS_BITS = 3;

   // Commands
   localparam logic [CMD_BITS-1:0] CMD_READ_SET  = 2'd0;
   localparam logic [CMD_BITS-1:0] CMD_WRITE_SET = 2'd1;
   localparam logic [CMD_BITS-1:0] CMD_ROLLBACK  = 2'd2;
   localparam logic [CMD_BITS-1:0] CMD_QUERY     = 2'd3;

   // Result status
   localparam logic [STATUS_BITS-1:0] ST_STORED      = 3'd0;
   localparam logic [STATUS_BITS-1:0] ST_EQUAL       = 3'd1;
   localparam logic [STATUS_BITS-1:0] ST_SMALLER     = 3'd2;
   localparam logic [STATUS_BITS-1:0] ST_UNKNOWN     = 3'd3;
   localparam logic [STATUS_BITS-1:0] ST_NOT_SMALLER = 3'd4;
   localparam logic [STATUS_BITS-1:0] ST_UNDERFLOW   = 3'd5;
   localparam logic [STATUS_BITS-1:0] ST_FULL        = 3'd6;

   // Request tdata layout
   localparam int REQ_CMD_LSB   = 0;
   localparam int REQ_ID_LSB    = REQ_CMD_LSB + CMD_BITS;
   localparam int REQ_TIME_LSB  = REQ_ID_LSB + ID_BITS;
   localparam int REQ_USED_BITS = REQ_TIME_LSB + TIME_BITS;
   localparam int REQ_DATA_BITS = ((REQ_USED_BITS + 7) / 8) * 8;

   // Response tdata layout
   localparam int RSP_STATUS_LSB = 0;
   localparam int RSP_FOUND_LSB  = RSP_STATUS_LSB + STATUS_BITS;
   localparam int RSP_LVT_LSB    = RSP_FOUND_LSB + 1;
   localparam int RSP_MIN_LSB    = RSP_LVT_LSB + TIME_BITS;
   localparam int RSP_LAST_LSB   = RSP_MIN_LSB + TIME_BITS;
   localparam int RSP_USED_BITS  = RSP_LAST_LSB + ID_BITS;
   localparam int RSP_DATA_BITS  = ((RSP_USED_BITS + 7) / 8) * 8;
   localparam int RSP_PAD_BITS   = RSP_DATA_BITS - RSP_USED_BITS;

   typedef logic [TIME_BITS-1:0] lvt_type;
   typedef logic [ID_BITS-1:0]   agent_type;

   localparam lvt_type LVT_ALL_ONES = '1;

   // One table entry
   typedef struct packed {
      agent_type agent;
      lvt_type   lvt;
   } entry_type;

   // Address width of a table of n entries
   function automatic int idx_bits(input int n);
      return (n > 1) ? $clog2(n) : 1;
   endfunction

endpackage

FILE: hdl/alvt_store.sv
// ----------------------------------------------------------------------------
// alvt_store
// Entry memory of the agent time table: one write port, one registered
// read port.
// ----------------------------------------------------------------------------
module alvt_store import alvt_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  logic                         clock,
   input  logic                         wr_en,
   input  logic [idx_bits(ENTRIES)-1:0] wr_addr,
   input  entry_type                    wr_data,
   input  logic                         rd_en,
   input  logic [idx_bits(ENTRIES)-1:0] rd_addr,
   output entry_type                    rd_data
);

   entry_type mem [ENTRIES];
   entry_type rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/agent_lvt_table_with_min_core.sv
// ----------------------------------------------------------------------------
// agent_lvt_table_with_min_core
// Table of agent IDs with a local virtual time each, running minimum and
// last set agent.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one command (read set, write set, rollback, query) for one
//   agent; rsp_* returns exactly one result per command with status, found
//   flag, the agent's time, the table minimum and the last set agent.
//   Both channels transfer on tvalid and tready high at a rising edge.
//   A command walks the N filled entries one a cycle through the registered
//   read port and drains it, then decides and writes back in one state and
//   forms the minimum and the result in the next; req_tready is high only
//   while no command is in progress, so a new command is taken only once
//   the last one has been loaded into the output register.
//   Entries fill from the lowest free slot and are never removed, so a fill
//   count marks the valid part; reset empties the table at once, clears the
//   last set agent and drops any pending result.
//   A finished result waits in the output register while the receiver
//   stalls; the next command is accepted meanwhile and its result is held
//   back until the register is free.
// ----------------------------------------------------------------------------
module agent_lvt_table_with_min_core import alvt_pkg::*; #(
   parameter int ENTRIES = ENTRIES_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   // Request channel
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [REQ_DATA_BITS-1:0] req_tdata,   // cmd, agent_id, time_value, zero pad
   // Result channel
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   output logic [RSP_DATA_BITS-1:0] rsp_tdata    // status, found, agent_lvt, min_lvt,
                                                 // last_agent, zero pad
);

   localparam int IDX_BITS = idx_bits(ENTRIES);
   localparam int CNT_BITS = $clog2(ENTRIES + 1);
   localparam logic [CNT_BITS-1:0] CNT_FULL = CNT_BITS'(ENTRIES);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_SCAN = 2'd1;
   localparam logic [1:0] S_EXEC = 2'd2;
   localparam logic [1:0] S_FIN  = 2'd3;

   logic [1:0]               state_ff, state_in;
   logic [CMD_BITS-1:0]      cmd_ff, cmd_in;
   agent_type                id_ff, id_in;
   lvt_type                  tv_ff, tv_in;
   logic [CNT_BITS-1:0]      count_ff, count_in;
   agent_type                last_agent_ff, last_agent_in;
   logic [CNT_BITS-1:0]      rd_idx_ff, rd_idx_in;
   logic                     data_ok_ff, data_ok_in;
   logic [IDX_BITS-1:0]      cmp_idx_ff, cmp_idx_in;
   logic                     found_ff, found_in;
   logic [IDX_BITS-1:0]      slot_ff, slot_in;
   lvt_type                  slot_lvt_ff, slot_lvt_in;
   lvt_type                  min_oth_ff, min_oth_in;
   logic [STATUS_BITS-1:0]   status_ff, status_in;
   logic                     present_ff, present_in;
   lvt_type                  lvt_after_ff, lvt_after_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_BITS-1:0] rsp_data_ff, rsp_data_in;

   logic                wr_en;
   logic [IDX_BITS-1:0] wr_addr;
   entry_type           wr_data;
   logic                rd_en;
   entry_type           rd_data;
   lvt_type             new_lvt;
   lvt_type             out_lvt;
   lvt_type             out_min;

   alvt_store #(
      .ENTRIES (ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff[IDX_BITS-1:0]),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // New time of a set or rollback: read set takes the time as given
   assign new_lvt = (cmd_ff == CMD_READ_SET) ? tv_ff : (tv_ff - lvt_type'(1));
   assign wr_data = '{agent: id_ff, lvt: new_lvt};

   // Result values from the decided entry and the minimum over the others
   assign out_lvt = present_ff ? lvt_after_ff : LVT_ALL_ONES;
   assign out_min = (present_ff && (lvt_after_ff < min_oth_ff)) ? lvt_after_ff : min_oth_ff;

   // Sequencer
   always_comb begin
      state_in      = state_ff;
      cmd_in        = cmd_ff;
      id_in         = id_ff;
      tv_in         = tv_ff;
      count_in      = count_ff;
      last_agent_in = last_agent_ff;
      rd_idx_in     = rd_idx_ff;
      data_ok_in    = 1'b0;
      cmp_idx_in    = cmp_idx_ff;
      found_in      = found_ff;
      slot_in       = slot_ff;
      slot_lvt_in   = slot_lvt_ff;
      min_oth_in    = min_oth_ff;
      status_in     = status_ff;
      present_in    = present_ff;
      lvt_after_in  = lvt_after_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;
      wr_en         = 1'b0;
      wr_addr       = slot_ff;
      rd_en         = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            // Take a command and start the walk from entry zero
            if (req_tvalid) begin
               cmd_in     = req_tdata[REQ_CMD_LSB +: CMD_BITS];
               id_in      = req_tdata[REQ_ID_LSB +: ID_BITS];
               tv_in      = req_tdata[REQ_TIME_LSB +: TIME_BITS];
               rd_idx_in  = '0;
               found_in   = 1'b0;
               min_oth_in = LVT_ALL_ONES;
               state_in   = S_SCAN;
            end
         end
         S_SCAN: begin
            // Issue the next read while the filled part lasts
            rd_en = (rd_idx_ff < count_ff);
            if (rd_en) begin
               rd_idx_in  = rd_idx_ff + CNT_BITS'(1);
               cmp_idx_in = rd_idx_ff[IDX_BITS-1:0];
            end
            data_ok_in = rd_en;
            // Match the agent, fold every other entry into the minimum
            if (data_ok_ff) begin
               if (!found_ff && (rd_data.agent == id_ff)) begin
                  found_in    = 1'b1;
                  slot_in     = cmp_idx_ff;
                  slot_lvt_in = rd_data.lvt;
               end else if (rd_data.lvt < min_oth_ff) begin
                  min_oth_in = rd_data.lvt;
               end
            end
            if (!rd_en && !data_ok_ff) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            present_in   = found_ff;
            lvt_after_in = slot_lvt_ff;
            unique case (cmd_ff) inside
               CMD_READ_SET, CMD_WRITE_SET: begin
                  if ((cmd_ff == CMD_WRITE_SET) && (tv_ff == '0)) begin
                     status_in = ST_UNDERFLOW;
                  end else begin
                     last_agent_in = id_ff;
                     if (!found_ff) begin
                        if (count_ff == CNT_FULL) begin
                           status_in = ST_FULL;
                        end else begin
                           // Insert in the lowest free entry
                           wr_en        = 1'b1;
                           wr_addr      = count_ff[IDX_BITS-1:0];
                           count_in     = count_ff + CNT_BITS'(1);
                           present_in   = 1'b1;
                           lvt_after_in = new_lvt;
                           status_in    = ST_STORED;
                        end
                     end else if (new_lvt == slot_lvt_ff) begin
                        status_in = ST_EQUAL;
                     end else if (new_lvt < slot_lvt_ff) begin
                        status_in = ST_SMALLER;
                     end else begin
                        wr_en        = 1'b1;
                        lvt_after_in = new_lvt;
                        status_in    = ST_STORED;
                     end
                  end
               end
               CMD_ROLLBACK: begin
                  if (!found_ff) begin
                     status_in = ST_UNKNOWN;
                  end else if (tv_ff == '0) begin
                     status_in = ST_UNDERFLOW;
                  end else begin
                     wr_en        = 1'b1;
                     lvt_after_in = new_lvt;
                     status_in    = (new_lvt > slot_lvt_ff) ? ST_NOT_SMALLER : ST_STORED;
                  end
               end
               CMD_QUERY: begin
                  status_in = found_ff ? ST_STORED : ST_UNKNOWN;
               end
            endcase
            state_in = S_FIN;
         end
         S_FIN: begin
            // Load the result once the output register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{RSP_PAD_BITS{1'b0}}, last_agent_ff, out_min, out_lvt,
                               found_ff, status_ff};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         last_agent_ff <= '0;
         data_ok_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         last_agent_ff <= last_agent_in;
         data_ok_ff    <= data_ok_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Payload and working registers
   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      id_ff        <= id_in;
      tv_ff        <= tv_in;
      rd_idx_ff    <= rd_idx_in;
      cmp_idx_ff   <= cmp_idx_in;
      found_ff     <= found_in;
      slot_ff      <= slot_in;
      slot_lvt_ff  <= slot_lvt_in;
      min_oth_ff   <= min_oth_in;
      status_ff    <= status_in;
      present_ff   <= present_in;
      lvt_after_ff <= lvt_after_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule

FILE: hdl/alvt_checker.sv
// ----------------------------------------------------------------------------
// alvt_checker
// Port-level checks of the agent time table, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module alvt_checker import alvt_pkg::*; (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_tvalid,
   input logic                     req_tready,
   input logic                     rsp_tvalid,
   input logic                     rsp_tready,
   input logic [RSP_DATA_BITS-1:0] rsp_tdata
);

   lvt_type                rsp_lvt;
   lvt_type                rsp_min;
   logic [STATUS_BITS-1:0] rsp_status;
   logic                   rsp_absent;

   assign rsp_lvt    = rsp_tdata[RSP_LVT_LSB +: TIME_BITS];
   assign rsp_min    = rsp_tdata[RSP_MIN_LSB +: TIME_BITS];
   assign rsp_status = rsp_tdata[RSP_STATUS_LSB +: STATUS_BITS];

   // Agent neither present before nor inserted by the command
   assign rsp_absent = !rsp_tdata[RSP_FOUND_LSB] && (rsp_status != ST_STORED);

   // A command is worked on before the next is taken: no back-to-back transfer
   `ALVT_ASSERT_CLK(a_busy_after_req, (req_tvalid && req_tready |=> !req_tready))

   // A stalled result stays offered
   `ALVT_ASSERT_CLK(a_rsp_hold, (rsp_tvalid && !rsp_tready |=> rsp_tvalid))

   // The table minimum never exceeds the reported agent time
   `ALVT_ASSERT_CLK(a_min_le_lvt, (rsp_tvalid |-> rsp_min <= rsp_lvt))

   // An absent agent that was not inserted reports all-ones
   `ALVT_ASSERT_CLK(a_absent_ones, (rsp_tvalid && rsp_absent |-> rsp_lvt == LVT_ALL_ONES))

endmodule

bind agent_lvt_table_with_min_core alvt_checker u_alvt_checker (.*);
